// ===== hdl/hws_pkg.sv =====
// Shared types and constants of the Holt-Winters smoother.
package hws_pkg;

  localparam int GAIN_W     = 17;     // Q1.16 gain, 65536 means one
  localparam int LEN_W      = 7;      // season length register
  localparam int HZN_W      = 7;      // horizon and step index
  localparam int CFG_IDX_W  = 3;
  localparam int FRAC_BITS  = 16;
  localparam int ONE_Q16    = 65536;
  localparam int ROUND_HALF = 32768;

  typedef enum logic {
    OP_UPDATE   = 1'b0,
    OP_FORECAST = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_BAD_HZN = 2'd1,
    STAT_DIV0    = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL_GAIN  = 3'd0,
    CFG_TREND_GAIN  = 3'd1,
    CFG_SEASON_GAIN = 3'd2,
    CFG_MULT_MODE   = 3'd3,
    CFG_SEASON_LEN  = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    ALU_MUL = 1'b0,
    ALU_DIV = 1'b1
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_ctl_t;

endpackage

// ===== hdl/holt_winters_smoother.sv =====
// Holt-Winters smoother top level: configuration, sequencer and result register.
//
//  channel  | signals                                        | direction
//  ---------+------------------------------------------------+----------
//  request  | in_valid_i/in_ready_o, op_i, sample_i, horizon_i | in
//  result   | out_valid_o/out_ready_i, value_o, step_index_o, | out
//           | status_o, last_o                               |
//  config   | cfg_we_i, cfg_idx_i, cfg_data_i                | in
//
// After reset the seasonal store is swept to zero before the first request
// is taken. The first update sweeps it again with the fill value. A later
// update runs three serial multiplies plus, in multiplicative mode, two
// serial divides, each skipped when its divisor is zero. A forecast step
// uses one serial multiply in multiplicative mode only. The arithmetic is
// done by the single one-bit-per-cycle unit. A stalled result holds only
// its own register; the next request is taken while it waits.
module holt_winters_smoother import hws_pkg::*; #(
  parameter int SEASON_MAX  = 64,
  parameter int HORIZON_MAX = 64,
  parameter int DATA_WIDTH  = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          op_i,
  input  logic signed [DATA_WIDTH-1:0]  sample_i,
  input  logic [HZN_W-1:0]              horizon_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [DATA_WIDTH-1:0]  value_o,
  output logic [HZN_W-1:0]              step_index_o,
  output logic [1:0]                    status_o,
  output logic                          last_o,
  input  logic                          cfg_we_i,
  input  logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic [GAIN_W-1:0]             cfg_data_i
);

  localparam int W   = DATA_WIDTH;
  localparam int HW  = $clog2(HORIZON_MAX + 1);
  localparam int AW  = $clog2(SEASON_MAX);
  localparam int LW  = $clog2(SEASON_MAX + 1);
  localparam int LX  = (LW > LEN_W) ? LW : LEN_W;
  localparam int XW  = W + HW + 1;   // forecast base and blend difference
  localparam int MB  = W + 2;        // multiplier operand
  localparam int PW  = XW + MB;      // product

  localparam logic signed [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_URD, ST_UA, ST_UA_W, ST_UL, ST_UL_W, ST_UT, ST_UT_W,
    ST_UC, ST_UC_W, ST_US, ST_US_W, ST_EMIT, ST_FRD, ST_FS, ST_FM_W, ST_FOUT
  } state_e;

  function automatic logic signed [W-1:0] sat_w(input logic signed [PW-1:0] v);
    if ((v[PW-1:W-1] == '0) || (v[PW-1:W-1] == '1)) begin
      return v[W-1:0];
    end
    return v[PW-1] ? VMIN : VMAX;
  endfunction

  function automatic logic [MB-1:0] gain_clamp(input logic [GAIN_W-1:0] g);
    return g[GAIN_W-1] ? MB'(ONE_Q16) : MB'(g);
  endfunction

  // configuration and model state
  logic [GAIN_W-1:0]    lg_q, tg_q, sg_q;
  logic                 mult_q;
  logic [LEN_W-1:0]     slen_q;
  logic signed [W-1:0]  level_q, trend_q;
  logic [AW-1:0]        head_q;
  logic                 started_q;

  // sequencer
  state_e               state_q;
  logic [AW-1:0]        k_q, clr_q;
  logic                 emit_q, zero_q;
  status_e              st_q;
  logic signed [W-1:0]  y_q;
  logic [HZN_W-1:0]     hz_q, h_q;
  logic signed [W:0]    a_q;
  logic signed [XW-1:0] b_q, base_q;
  logic signed [W-1:0]  ln_q, tn_q, v_q;

  // result register
  logic                 out_valid_q, last_q;
  logic signed [W-1:0]  value_q;
  logic [HZN_W-1:0]     step_q;
  status_e              status_q;

  // datapath
  alu_ctl_t             alu_ctl;
  logic signed [XW-1:0] alu_x;
  logic signed [MB-1:0] alu_m;
  logic signed [PW-1:0] alu_prod, rnd;
  logic signed [W-1:0]  alu_quot, s_w, blend_res, fc_add, fc_mul, fill_w, zq;
  logic                 alu_done, out_free, out_load;
  logic [LX-1:0]        len, slen_x, kp1;
  logic [AW-1:0]        k_next, head_eff;
  logic                 ring_we;
  logic [AW-1:0]        ring_waddr;
  logic signed [W-1:0]  ring_wdata;

  // effective season length: zero reads as one, oversized as SEASON_MAX
  assign slen_x   = LX'(slen_q);
  assign len      = (slen_q == '0) ? LX'(1) :
                    ((slen_x > LX'(SEASON_MAX)) ? LX'(SEASON_MAX) : slen_x);
  assign head_eff = (LX'(head_q) < len) ? head_q : '0;
  assign kp1      = LX'(k_q) + LX'(1);
  assign k_next   = (kp1 >= len) ? '0 : kp1[AW-1:0];

  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = ((state_q == ST_EMIT) || (state_q == ST_FOUT)) && out_free;
  assign in_ready_o = (state_q == ST_IDLE);

  // round to nearest, ties up, then drop the 16 fraction bits
  assign rnd       = (alu_prod + PW'(ROUND_HALF)) >>> FRAC_BITS;
  assign blend_res = sat_w(PW'(b_q) + rnd);
  assign fc_mul    = sat_w(rnd);
  assign fc_add    = sat_w(PW'(base_q) + PW'(s_w));
  assign fill_w    = (emit_q && mult_q) ? sat_w(PW'(ONE_Q16)) : '0;
  assign zq        = (y_q == '0) ? '0 : (y_q[W-1] ? VMIN : VMAX);

  // select operands for the shared unit
  always_comb begin
    alu_ctl = '{start: 1'b0, op: ALU_MUL};
    alu_x   = '0;
    alu_m   = '0;
    unique case (state_q)
      ST_UA: begin
        alu_ctl = '{start: mult_q && (s_w != '0), op: ALU_DIV};
        alu_x   = XW'(y_q);
        alu_m   = MB'(s_w);
      end
      ST_UC: begin
        alu_ctl = '{start: mult_q && (ln_q != '0), op: ALU_DIV};
        alu_x   = XW'(y_q);
        alu_m   = MB'(ln_q);
      end
      ST_UL: begin
        alu_ctl = '{start: 1'b1, op: ALU_MUL};
        alu_x   = XW'(a_q) - (XW'(level_q) + XW'(trend_q));
        alu_m   = gain_clamp(lg_q);
      end
      ST_UT: begin
        alu_ctl = '{start: 1'b1, op: ALU_MUL};
        alu_x   = XW'(ln_q) - XW'(level_q) - XW'(trend_q);
        alu_m   = gain_clamp(tg_q);
      end
      ST_US: begin
        alu_ctl = '{start: 1'b1, op: ALU_MUL};
        alu_x   = XW'(a_q) - XW'(s_w);
        alu_m   = gain_clamp(sg_q);
      end
      ST_FS: begin
        alu_ctl = '{start: mult_q, op: ALU_MUL};
        alu_x   = base_q;
        alu_m   = MB'(s_w);
      end
      default: begin
        alu_ctl = '{start: 1'b0, op: ALU_MUL};
      end
    endcase
  end

  // store writes: sweep, or the refreshed factor at the end of an update
  assign ring_we    = (state_q == ST_CLEAR) || ((state_q == ST_US_W) && alu_done);
  assign ring_waddr = (state_q == ST_CLEAR) ? clr_q : k_q;
  assign ring_wdata = (state_q == ST_CLEAR) ? fill_w : blend_res;

  hws_alu #(
    .W  (W),
    .XW (XW),
    .MB (MB)
  ) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (alu_ctl),
    .x_i    (alu_x),
    .m_i    (alu_m),
    .prod_o (alu_prod),
    .quot_o (alu_quot),
    .done_o (alu_done)
  );

  hws_ring #(
    .W     (W),
    .DEPTH (SEASON_MAX),
    .AW    (AW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (ring_waddr),
    .wdata_i (ring_wdata),
    .raddr_i (k_q),
    .rdata_o (s_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      emit_q      <= 1'b0;
      started_q   <= 1'b0;
      level_q     <= '0;
      trend_q     <= '0;
      head_q      <= '0;
      lg_q        <= GAIN_W'(19661);
      tg_q        <= GAIN_W'(6554);
      sg_q        <= GAIN_W'(6554);
      mult_q      <= 1'b0;
      slen_q      <= LEN_W'(12);
      out_valid_q <= 1'b0;
    end else begin
      // drop the result once it is taken, unless a new one loads below
      if (out_valid_q && out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LEVEL_GAIN:  lg_q <= cfg_data_i;
          CFG_TREND_GAIN:  tg_q <= cfg_data_i;
          CFG_SEASON_GAIN: sg_q <= cfg_data_i;
          CFG_MULT_MODE:   mult_q <= cfg_data_i[0];
          CFG_SEASON_LEN: begin
            slen_q <= cfg_data_i[LEN_W-1:0];
            head_q <= '0;
          end
          default: ;
        endcase
      end

      unique case (state_q)
        ST_CLEAR: begin
          if (clr_q == AW'(SEASON_MAX - 1)) begin
            clr_q   <= '0;
            state_q <= emit_q ? ST_EMIT : ST_IDLE;
          end else begin
            clr_q <= clr_q + AW'(1);
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            y_q    <= sample_i;
            hz_q   <= horizon_i;
            zero_q <= 1'b0;
            k_q    <= head_eff;
            if (op_e'(op_i) == OP_UPDATE) begin
              st_q <= STAT_OK;
              if (!started_q) begin
                // first sample: seed level, clear trend, refill the store
                level_q   <= sample_i;
                trend_q   <= '0;
                head_q    <= '0;
                started_q <= 1'b1;
                emit_q    <= 1'b1;
                state_q   <= ST_CLEAR;
              end else begin
                state_q <= ST_URD;
              end
            end else if ((horizon_i == '0) || (horizon_i > HZN_W'(HORIZON_MAX))) begin
              st_q    <= STAT_BAD_HZN;
              state_q <= ST_EMIT;
            end else begin
              base_q  <= XW'(level_q) + XW'(trend_q);
              h_q     <= HZN_W'(1);
              state_q <= ST_FRD;
            end
          end
        end
        ST_URD: state_q <= ST_UA;
        ST_UA: begin
          if (!mult_q) begin
            a_q     <= (W+1)'(y_q) - (W+1)'(s_w);
            state_q <= ST_UL;
          end else if (s_w == '0) begin
            a_q     <= (W+1)'(zq);
            zero_q  <= 1'b1;
            state_q <= ST_UL;
          end else begin
            state_q <= ST_UA_W;
          end
        end
        ST_UA_W: begin
          if (alu_done) begin
            a_q     <= (W+1)'(alu_quot);
            state_q <= ST_UL;
          end
        end
        ST_UL: begin
          b_q     <= XW'(level_q) + XW'(trend_q);
          state_q <= ST_UL_W;
        end
        ST_UL_W: begin
          if (alu_done) begin
            ln_q    <= blend_res;
            state_q <= ST_UT;
          end
        end
        ST_UT: begin
          b_q     <= XW'(trend_q);
          state_q <= ST_UT_W;
        end
        ST_UT_W: begin
          if (alu_done) begin
            tn_q    <= blend_res;
            state_q <= ST_UC;
          end
        end
        ST_UC: begin
          if (!mult_q) begin
            a_q     <= (W+1)'(y_q) - (W+1)'(ln_q);
            state_q <= ST_US;
          end else if (ln_q == '0) begin
            a_q     <= (W+1)'(zq);
            zero_q  <= 1'b1;
            state_q <= ST_US;
          end else begin
            state_q <= ST_UC_W;
          end
        end
        ST_UC_W: begin
          if (alu_done) begin
            a_q     <= (W+1)'(alu_quot);
            state_q <= ST_US;
          end
        end
        ST_US: begin
          b_q     <= XW'(s_w);
          state_q <= ST_US_W;
        end
        ST_US_W: begin
          if (alu_done) begin
            // commit: the ring write happens alongside
            level_q <= ln_q;
            trend_q <= tn_q;
            head_q  <= k_next;
            st_q    <= zero_q ? STAT_DIV0 : STAT_OK;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            value_q     <= '0;
            step_q      <= '0;
            status_q    <= st_q;
            last_q      <= 1'b1;
            emit_q      <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        ST_FRD: state_q <= ST_FS;
        ST_FS: begin
          if (mult_q) begin
            state_q <= ST_FM_W;
          end else begin
            v_q     <= fc_add;
            state_q <= ST_FOUT;
          end
        end
        ST_FM_W: begin
          if (alu_done) begin
            v_q     <= fc_mul;
            state_q <= ST_FOUT;
          end
        end
        ST_FOUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            value_q     <= v_q;
            step_q      <= h_q;
            status_q    <= STAT_OK;
            last_q      <= (h_q == hz_q);
            if (h_q == hz_q) begin
              state_q <= ST_IDLE;
            end else begin
              // advance to the next step: one more trend, next season slot
              h_q     <= h_q + HZN_W'(1);
              base_q  <= base_q + XW'(trend_q);
              k_q     <= k_next;
              state_q <= ST_FRD;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = value_q;
  assign step_index_o = step_q;
  assign status_o     = status_q;
  assign last_o       = last_q;

endmodule

// ===== hdl/hws_alu.sv =====
// Serial arithmetic unit: shift-add signed multiply and restoring Q16 divide.
module hws_alu import hws_pkg::*; #(
  parameter int W  = 32,
  parameter int XW = 40,
  parameter int MB = 34
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  alu_ctl_t                 ctl_i,
  input  logic signed [XW-1:0]     x_i,
  input  logic signed [MB-1:0]     m_i,
  output logic signed [XW+MB-1:0]  prod_o,
  output logic signed [W-1:0]      quot_o,
  output logic                     done_o
);

  localparam int PW = XW + MB;
  localparam int DN = W + FRAC_BITS;
  localparam int CW = $clog2(DN + 1);

  logic                  busy_q, done_q;
  alu_op_e               op_q;
  logic [CW-1:0]         cnt_q;
  logic signed [PW-1:0]  acc_q, mcand_q;
  logic [MB-1:0]         mplier_q;
  logic [W-1:0]          rem_q, dvs_q;
  logic [DN-1:0]         quo_q;
  logic                  neg_q;

  logic [W-1:0]  x_mag, m_mag;
  logic [W:0]    rem_sh;
  logic [W+1:0]  diff;
  logic          mul_last, div_last;

  assign x_mag    = x_i[W-1] ? (~x_i[W-1:0] + W'(1)) : x_i[W-1:0];
  assign m_mag    = m_i[W-1] ? (~m_i[W-1:0] + W'(1)) : m_i[W-1:0];
  assign rem_sh   = {rem_q, quo_q[DN-1]};
  assign diff     = {1'b0, rem_sh} - {2'b00, dvs_q};
  assign mul_last = (cnt_q == CW'(MB - 1));
  assign div_last = (cnt_q == CW'(DN - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (ctl_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      if (op_q == ALU_MUL) begin
        busy_q <= !mul_last;
        done_q <= mul_last;
      end else begin
        busy_q <= !div_last;
        done_q <= div_last;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      op_q     <= ctl_i.op;
      cnt_q    <= '0;
      acc_q    <= '0;
      mcand_q  <= PW'(x_i);
      mplier_q <= m_i;
      rem_q    <= '0;
      quo_q    <= {x_mag, {FRAC_BITS{1'b0}}};
      dvs_q    <= m_mag;
      neg_q    <= x_i[W-1] ^ m_i[W-1];
    end else if (busy_q) begin
      cnt_q <= cnt_q + CW'(1);
      if (op_q == ALU_MUL) begin
        // sign bit of the multiplier carries negative weight
        if (mplier_q[0]) begin
          acc_q <= mul_last ? (acc_q - mcand_q) : (acc_q + mcand_q);
        end
        mcand_q  <= mcand_q <<< 1;
        mplier_q <= mplier_q >> 1;
      end else begin
        if (!diff[W+1]) begin
          rem_q <= diff[W-1:0];
          quo_q <= {quo_q[DN-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[W-1:0];
          quo_q <= {quo_q[DN-2:0], 1'b0};
        end
      end
    end
  end

  // saturate the signed quotient to W bits
  always_comb begin
    if (!neg_q) begin
      quot_o = (|quo_q[DN-1:W-1]) ? {1'b0, {(W-1){1'b1}}} : quo_q[W-1:0];
    end else if ((|quo_q[DN-1:W]) || (quo_q[W-1] && (|quo_q[W-2:0]))) begin
      quot_o = {1'b1, {(W-1){1'b0}}};
    end else begin
      quot_o = ~quo_q[W-1:0] + W'(1);
    end
  end

  assign prod_o = acc_q;
  assign done_o = done_q;

endmodule

// ===== hdl/hws_ring.sv =====
// Seasonal factor store: one write port, one registered read port.
module hws_ring import hws_pkg::*; #(
  parameter int W     = 32,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic signed [W-1:0]  wdata_i,
  input  logic [AW-1:0]        raddr_i,
  output logic signed [W-1:0]  rdata_o
);

  logic signed [W-1:0] mem_q [DEPTH];
  logic signed [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
